>>> design/clebuf_pkg.sv
// Shared types and constants for the cursor line-edit buffer.
// No dependencies; used by every other file in the design folder.
package clebuf_pkg;

  // Text capacity in characters and width of positions/counts
  localparam int CAPACITY = 63;
  localparam int IDX_W    = $clog2(CAPACITY + 1);

  // Key codes
  localparam logic [7:0] KEY_LEFT  = 8'h4C;
  localparam logic [7:0] KEY_RIGHT = 8'h52;
  localparam logic [7:0] KEY_BACK  = 8'h42;
  localparam logic [7:0] KEY_LOW_A = 8'h61;
  localparam logic [7:0] KEY_LOW_Z = 8'h7A;
  localparam logic [7:0] NEWLINE   = 8'h0A;

  // Operation codes of an input item
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DUMP = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] key;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic             ins;    // insert key at pivot, shift tail right
    logic             del;    // remove char at pivot, shift tail left
    logic             shl;    // shift whole row left (dump)
    logic [IDX_W-1:0] pivot;
    logic [7:0]       key;
  } cell_ctrl_t;

endpackage

>>> design/cursor_line_edit_buffer.sv
// Cursor line-edit buffer: top level with control, cursor/length counters and cell row.
// Depends on clebuf_pkg and clebuf_cell.
//
// The text is held in order in a row of 63 character cells; the cursor is a
// position counter. A key item leaves busy low, so the next item may follow
// in the next cycle. Insert and delete shift the cells right of the cursor
// by one place. A dump item raises busy and then emits one character per
// cycle by shifting the row toward cell 0, followed by a newline marked
// last. Busy stays high until the newline comes out, and the results are
// registered. Results come out on out_valid for one cycle each and cannot
// be stalled. The buffer is empty after reset and after each dump.
module cursor_line_edit_buffer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  clebuf_pkg::in_item_t  in_item,
  output logic                  out_valid,
  output clebuf_pkg::out_item_t out_item
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  localparam int W = clebuf_pkg::IDX_W;
  localparam logic [W-1:0] CAP = W'(clebuf_pkg::CAPACITY);

  logic                   state_r, state_nxt;
  logic [W-1:0]           cursor_r, cursor_nxt;
  logic [W-1:0]           total_r, total_nxt;
  logic                   out_valid_r, out_valid_nxt;
  clebuf_pkg::out_item_t  out_item_r, out_item_nxt;
  clebuf_pkg::cell_ctrl_t ctrl;
  logic                   accept;
  logic [7:0]             cell_char [clebuf_pkg::CAPACITY];

  assign busy   = (state_r == ST_DUMP);
  assign accept = start && !busy;

  // Key decode, cursor/length update and dump sequencing
  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    total_nxt     = total_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ctrl          = '0;
    ctrl.key      = in_item.key;
    ctrl.pivot    = cursor_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_item.operation == clebuf_pkg::OP_DUMP)) begin
          state_nxt  = ST_DUMP;
          cursor_nxt = '0;
        end else if (accept) begin
          unique case (in_item.key)
            clebuf_pkg::KEY_LEFT: begin
              if (cursor_r != '0) begin
                cursor_nxt = cursor_r - 1'b1;
              end
            end
            clebuf_pkg::KEY_RIGHT: begin
              if (cursor_r != total_r) begin
                cursor_nxt = cursor_r + 1'b1;
              end
            end
            clebuf_pkg::KEY_BACK: begin
              if (cursor_r != '0) begin
                ctrl.del   = 1'b1;
                ctrl.pivot = cursor_r - 1'b1;
                cursor_nxt = cursor_r - 1'b1;
                total_nxt  = total_r - 1'b1;
              end
            end
            default: begin
              if ((in_item.key >= clebuf_pkg::KEY_LOW_A) &&
                  (in_item.key <= clebuf_pkg::KEY_LOW_Z) && (total_r != CAP)) begin
                ctrl.ins   = 1'b1;
                cursor_nxt = cursor_r + 1'b1;
                total_nxt  = total_r + 1'b1;
              end
            end
          endcase
        end
      end
      ST_DUMP: begin
        out_valid_nxt = 1'b1;
        if (total_r != '0) begin
          ctrl.shl               = 1'b1;
          out_item_nxt.character = cell_char[0];
          out_item_nxt.last      = 1'b0;
          total_nxt              = total_r - 1'b1;
        end else begin
          out_item_nxt.character = clebuf_pkg::NEWLINE;
          out_item_nxt.last      = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_r    <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Row of character cells, cell 0 holds the first character
  for (genvar i = 0; i < clebuf_pkg::CAPACITY; i++) begin : g_cell
    logic [7:0] left_c;
    logic [7:0] right_c;
    if (i == 0) begin : g_first
      assign left_c = 8'h00;
    end else begin : g_mid_l
      assign left_c = cell_char[i-1];
    end
    if (i == clebuf_pkg::CAPACITY - 1) begin : g_end
      assign right_c = cell_char[i];
    end else begin : g_mid_r
      assign right_c = cell_char[i+1];
    end
    clebuf_cell u_cell (
      .clk        (clk),
      .idx        (W'(i)),
      .ctrl       (ctrl),
      .left_char  (left_c),
      .right_char (right_c),
      .char_q     (cell_char[i])
    );
  end

endmodule

>>> design/clebuf_cell.sv
// One character cell of the text row; trades data with both neighbors.
// Depends on clebuf_pkg.
module clebuf_cell (
  input  logic                           clk,
  input  logic [clebuf_pkg::IDX_W-1:0]   idx,
  input  clebuf_pkg::cell_ctrl_t         ctrl,
  input  logic [7:0]                     left_char,
  input  logic [7:0]                     right_char,
  output logic [7:0]                     char_q
);

  logic [7:0] char_r;
  logic [7:0] char_nxt;

  // Pick the new content: key, left neighbor, right neighbor or hold
  always_comb begin
    if (ctrl.ins && (idx == ctrl.pivot)) begin
      char_nxt = ctrl.key;
    end else if (ctrl.ins && (idx > ctrl.pivot)) begin
      char_nxt = left_char;
    end else if (ctrl.shl || (ctrl.del && (idx >= ctrl.pivot))) begin
      char_nxt = right_char;
    end else begin
      char_nxt = char_r;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  assign char_q = char_r;

endmodule

>>> design/clebuf_chk.sv
// Port-level checker for the cursor line-edit buffer, bound to the top level.
// Depends on clebuf_pkg and cursor_line_edit_buffer.
module clebuf_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input clebuf_pkg::in_item_t  in_item,
  input logic                  out_valid,
  input clebuf_pkg::out_item_t out_item
);

  // A dump item makes the block busy
  a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.operation == clebuf_pkg::OP_DUMP) |=> busy)
    else $error("dump item did not raise busy");

  // A key item completes at once
  a_key_free: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.operation == clebuf_pkg::OP_KEY) |=> !busy)
    else $error("key item raised busy");

  // Busy ends together with the closing newline
  a_end_nl: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |->
      out_valid && out_item.last && (out_item.character == clebuf_pkg::NEWLINE))
    else $error("busy ended without closing newline");

  // A text character only comes out while the dump still holds busy
  a_char_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> busy)
    else $error("text character outside a dump");

  // Nothing follows the newline directly
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |=> !out_valid)
    else $error("result right after closing newline");

endmodule

bind cursor_line_edit_buffer clebuf_chk u_clebuf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

>>> tb/tb.sv
// Self-checking testbench for cursor_line_edit_buffer: a directed edit script, then random
// edit sessions, each checked against a queue-based model of the line and cursor.
// Depends on clebuf_pkg and the RTL of cursor_line_edit_buffer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TOTAL   = 310;   // least number of input items sent over the run
  localparam int CALM_TAIL    = 40;    // sessions begun this near the end send back to back
  localparam int STALL_LIMIT  = 2000;  // cycles with no item in or out
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    clebuf_pkg::in_item_t item;
    bit                   pinned;  // dump text typed in below instead of predicted
    string                text;
  } edit_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  clebuf_pkg::in_item_t  in_item = '0;
  logic                  out_valid;
  clebuf_pkg::out_item_t out_item;

  // line model: text left of the cursor and right of it, both in text order
  logic [7:0]            before_cursor[$];
  logic [7:0]            after_cursor[$];
  clebuf_pkg::out_item_t expected_text[$];
  clebuf_pkg::out_item_t want;

  edit_row_t  edit_script[$];
  int         mismatch_count = 0;
  int         idle_run = 0;
  int         items_sent = 0;
  bit         quiet = 1'b0;

  cursor_line_edit_buffer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one item to the line model; dump text goes to chars.
  function automatic void edit_line(clebuf_pkg::in_item_t it,
                                    ref clebuf_pkg::out_item_t chars[$]);
    if (it.operation == clebuf_pkg::OP_DUMP) begin
      foreach (before_cursor[i])
        chars.push_back(clebuf_pkg::out_item_t'{character: before_cursor[i], last: 1'b0});
      foreach (after_cursor[i])
        chars.push_back(clebuf_pkg::out_item_t'{character: after_cursor[i], last: 1'b0});
      chars.push_back(clebuf_pkg::out_item_t'{character: clebuf_pkg::NEWLINE, last: 1'b1});
      before_cursor.delete();
      after_cursor.delete();
    end else if (it.key == clebuf_pkg::KEY_LEFT) begin
      if (before_cursor.size() > 0)
        after_cursor.push_front(before_cursor.pop_back());
    end else if (it.key == clebuf_pkg::KEY_RIGHT) begin
      if (after_cursor.size() > 0)
        before_cursor.push_back(after_cursor.pop_front());
    end else if (it.key == clebuf_pkg::KEY_BACK) begin
      if (before_cursor.size() > 0)
        void'(before_cursor.pop_back());
    end else if (it.key >= clebuf_pkg::KEY_LOW_A && it.key <= clebuf_pkg::KEY_LOW_Z) begin
      // insert into a full line is dropped
      if (before_cursor.size() + after_cursor.size() < clebuf_pkg::CAPACITY)
        before_cursor.push_back(it.key);
    end
  endfunction

  task automatic note_mismatch(string field, logic [7:0] want_val, logic [7:0] got_val);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch: expected %02h, got %02h", $realtime, field, want_val,
               got_val);
  endtask

  // Sends one item, waits for it to be taken and queues the text it should produce
  task automatic send_item(clebuf_pkg::in_item_t it, bit pinned, string text);
    clebuf_pkg::out_item_t chars[$];
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start   <= 1'b0;
      in_item <= clebuf_pkg::in_item_t'(9'($urandom_range(0, 511)));
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
    edit_line(it, chars);
    if (pinned) begin
      chars.delete();
      for (int i = 0; i < text.len(); i++)
        chars.push_back(clebuf_pkg::out_item_t'{character: text[i], last: 1'b0});
      chars.push_back(clebuf_pkg::out_item_t'{character: clebuf_pkg::NEWLINE, last: 1'b1});
    end
    foreach (chars[i])
      expected_text.push_back(chars[i]);
  endtask

  task automatic add_row(logic op, logic [7:0] key, bit pinned = 1'b0, string text = "");
    edit_row_t row;
    row.item   = {op, key};
    row.pinned = pinned;
    row.text   = text;
    edit_script.push_back(row);
  endtask

  function automatic logic [7:0] any_letter();
    return 8'($urandom_range(clebuf_pkg::KEY_LOW_A, clebuf_pkg::KEY_LOW_Z));
  endfunction

  // Result checker and stall counter
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid)
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (rst_n && out_valid) begin
      if (expected_text.size() == 0) begin
        note_mismatch("unexpected character", 8'h00, out_item.character);
      end else begin
        want = expected_text.pop_front();
        if (out_item.character !== want.character)
          note_mismatch("character", want.character, out_item.character);
        if (out_item.last !== want.last)
          note_mismatch("last", 8'(want.last), 8'(out_item.last));
      end
    end
  end

  // Watchdog
  initial begin
    while (idle_run < STALL_LIMIT) @(posedge clk);
    $display("cursor_line_edit_buffer regression: fail");
    $finish;
  end

  initial begin
    logic [7:0] key;
    int         len;
    bit         fill;
    int         roll;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed script: empty line, moves and delete at the edges, ignored bytes, edits
    add_row(clebuf_pkg::OP_DUMP, 8'h00, 1'b1, "");
    add_row(clebuf_pkg::OP_KEY, clebuf_pkg::KEY_LEFT);
    add_row(clebuf_pkg::OP_KEY, clebuf_pkg::KEY_RIGHT);
    add_row(clebuf_pkg::OP_KEY, clebuf_pkg::KEY_BACK);
    add_row(clebuf_pkg::OP_KEY, clebuf_pkg::KEY_LOW_A);
    add_row(clebuf_pkg::OP_KEY, clebuf_pkg::KEY_LOW_Z);
    add_row(clebuf_pkg::OP_KEY, 8'h6D);
    add_row(clebuf_pkg::OP_KEY, 8'h00);
    add_row(clebuf_pkg::OP_KEY, 8'hFF);
    add_row(clebuf_pkg::OP_KEY, 8'h41);
    add_row(clebuf_pkg::OP_KEY, 8'h60);
    add_row(clebuf_pkg::OP_KEY, 8'h7B);
    add_row(clebuf_pkg::OP_KEY, clebuf_pkg::KEY_LEFT);
    add_row(clebuf_pkg::OP_KEY, clebuf_pkg::KEY_LEFT);
    add_row(clebuf_pkg::OP_KEY, 8'h71);
    add_row(clebuf_pkg::OP_KEY, clebuf_pkg::KEY_RIGHT);
    add_row(clebuf_pkg::OP_KEY, clebuf_pkg::KEY_BACK);
    add_row(clebuf_pkg::OP_DUMP, 8'hFF);
    add_row(clebuf_pkg::OP_DUMP, 8'h55, 1'b1, "");
    foreach (edit_script[i])
      send_item(edit_script[i].item, edit_script[i].pinned, edit_script[i].text);

    // random sessions of edits closed by a dump; some try to fill the line past capacity
    fill = 1'b1;
    while (items_sent < ITEM_TOTAL) begin
      quiet = ($urandom_range(0, 3) == 0) || (items_sent >= ITEM_TOTAL - CALM_TAIL);
      len   = fill ? $urandom_range(clebuf_pkg::CAPACITY + 1, clebuf_pkg::CAPACITY + 12)
                   : $urandom_range(1, 20);
      for (int n = 0; n < len; n++) begin
        roll = $urandom_range(0, 99);
        if (fill)
          key = (roll < 90) ? any_letter()
                            : ((roll < 95) ? clebuf_pkg::KEY_LEFT : clebuf_pkg::KEY_RIGHT);
        else if (roll < 55)
          key = any_letter();
        else if (roll < 68)
          key = clebuf_pkg::KEY_LEFT;
        else if (roll < 80)
          key = clebuf_pkg::KEY_RIGHT;
        else if (roll < 90)
          key = clebuf_pkg::KEY_BACK;
        else
          key = 8'($urandom_range(0, 255));
        send_item({clebuf_pkg::OP_KEY, key}, 1'b0, "");
      end
      send_item({clebuf_pkg::OP_DUMP, 8'($urandom_range(0, 255))}, 1'b0, "");
      fill = ($urandom_range(0, 9) == 0);
    end
    start <= 1'b0;

    // let the last dump drain
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("cursor_line_edit_buffer regression: pass");
    else
      $display("cursor_line_edit_buffer regression: fail");
    $finish;
  end

endmodule
